// ----- rtl/core/langevin_verlet_particle_step_top_assert.svh -----
// ----------------------------------------------------------------------------
// langevin verlet particle step assertion macros
// assertion forms for the particle stepper back end (lvps_back)
// ----------------------------------------------------------------------------
`ifndef LANGEVIN_VERLET_PARTICLE_STEP_TOP_ASSERT_SVH
`define LANGEVIN_VERLET_PARTICLE_STEP_TOP_ASSERT_SVH

// condition holds in the same cycle
`define LVPS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// condition holds in the next cycle
`define LVPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/lvps_pkg.sv -----
// ----------------------------------------------------------------------------
// lvps_pkg
// shared constants, types and helpers of the langevin particle stepper
// ----------------------------------------------------------------------------
package lvps_pkg;

   localparam int MAX_PARTICLES = 32;
   localparam int IDX_W         = $clog2(MAX_PARTICLES);
   localparam int CNT_W         = $clog2(MAX_PARTICLES + 1);

   // fixed field widths
   localparam int ACT_W   = 6;
   localparam int COEF_W  = 16;
   localparam int NOISE_W = 16;
   localparam int POS_W   = 32;
   localparam int PIDX_W  = 5;
   localparam int DENS_W  = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // density dividend is n shifted up by 40
   localparam int DENS_SHIFT = 40;
   localparam int DVD_W      = CNT_W + DENS_SHIFT;
   localparam int DVD_CNT_W  = $clog2(DVD_W + 1);

   // command queue between front and back
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   localparam logic signed [POS_W-1:0] S32_MAX = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic signed [POS_W-1:0] S32_MIN = {1'b1, {(POS_W-1){1'b0}}};

   localparam logic [COEF_W-1:0] GAMMA_RST  = COEF_W'(6554);
   localparam logic [COEF_W-1:0] SCALE_RST  = COEF_W'(66);
   localparam logic [ACT_W-1:0]  ACTIVE_RST = ACT_W'(25);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAMMA  = 2'd0,
      CSR_SCALE  = 2'd1,
      CSR_ACTIVE = 2'd2
   } csr_index_type;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_STEP = 1'b1
   } cmd_type;

   typedef enum logic {
      KIND_POS  = 1'b0,
      KIND_DENS = 1'b1
   } kind_type;

   // classified item handed from front to back
   typedef struct packed {
      cmd_type                    cmd;
      logic signed [NOISE_W-1:0]  noise;
      logic signed [POS_W-1:0]    init_pos;
      logic [IDX_W-1:0]           idx;
      logic                       end_tick;
      logic [CNT_W-1:0]           n;
   } q_entry_type;

   // per particle state word
   typedef struct packed {
      logic signed [POS_W-1:0] pos;
      logic signed [POS_W-1:0] vel;
      logic signed [POS_W-1:0] acc;
   } pstate_type;

   typedef struct packed {
      kind_type                kind;
      logic [PIDX_W-1:0]       pidx;
      logic signed [POS_W-1:0] position;
      logic [DENS_W-1:0]       density;
      logic                    span_zero;
      logic                    last;
   } result_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   function automatic logic signed [POS_W-1:0] sat32(input logic signed [39:0] x);
      logic signed [POS_W-1:0] res;
      if (x > 40'(S32_MAX)) begin
         res = S32_MAX;
      end else if (x < 40'(S32_MIN)) begin
         res = S32_MIN;
      end else begin
         res = x[POS_W-1:0];
      end
      return res;
   endfunction

endpackage

// ----- rtl/core/lvps_intf.sv -----
// ----------------------------------------------------------------------------
// lvps channel interfaces
// request, response and register write channels
// ----------------------------------------------------------------------------
interface lvps_req_if;
   import lvps_pkg::*;

   logic                      valid;
   logic                      ready;
   cmd_type                   command;
   logic signed [NOISE_W-1:0] noise_sample;
   logic signed [POS_W-1:0]   initial_position;

   modport source (output valid, command, noise_sample, initial_position, input ready);
   modport sink   (input valid, command, noise_sample, initial_position, output ready);
endinterface

interface lvps_rsp_if;
   import lvps_pkg::*;

   logic                    valid;
   logic                    ready;
   kind_type                result_kind;
   logic [PIDX_W-1:0]       particle_index;
   logic signed [POS_W-1:0] position;
   logic [DENS_W-1:0]       density;
   logic                    span_zero;
   logic                    last;

   modport source (output valid, result_kind, particle_index, position, density,
                   span_zero, last, input ready);
   modport sink   (input valid, result_kind, particle_index, position, density,
                   span_zero, last, output ready);
endinterface

interface lvps_csr_if;
   import lvps_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/lvps_front.sv -----
// ----------------------------------------------------------------------------
// lvps_front
// accepts items, assigns particle index and end of tick, feeds the queue
// ----------------------------------------------------------------------------
module lvps_front (
   input  logic                            clock,
   input  logic                            reset,
   lvps_req_if.sink                        req,
   input  logic [lvps_pkg::ACT_W-1:0]      active_particles,
   input  logic                            q_full,
   output logic                            q_push,
   output lvps_pkg::q_entry_type           q_wr_entry
);
   import lvps_pkg::*;

   logic [IDX_W-1:0] next_particle_ff;
   logic [IDX_W-1:0] next_particle_in;
   logic [CNT_W-1:0] n_eff;
   logic             end_tick;

   // clamp the active count to 1 .. MAX_PARTICLES
   always_comb begin
      if (active_particles == '0) begin
         n_eff = CNT_W'(1);
      end else if (int'(active_particles) > MAX_PARTICLES) begin
         n_eff = CNT_W'(MAX_PARTICLES);
      end else begin
         n_eff = CNT_W'(active_particles);
      end
   end

   assign end_tick  = CNT_W'(next_particle_ff) >= (n_eff - CNT_W'(1));
   assign req.ready = !q_full;
   assign q_push    = req.valid && !q_full;

   always_comb begin
      q_wr_entry.cmd      = req.command;
      q_wr_entry.noise    = req.noise_sample;
      q_wr_entry.init_pos = req.initial_position;
      q_wr_entry.idx      = next_particle_ff;
      q_wr_entry.end_tick = end_tick;
      q_wr_entry.n        = n_eff;
   end

   always_comb begin
      next_particle_in = next_particle_ff;
      if (q_push) begin
         next_particle_in = end_tick ? '0 : next_particle_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_particle_ff <= '0;
      end else begin
         next_particle_ff <= next_particle_in;
      end
   end

endmodule

// ----- rtl/core/lvps_queue.sv -----
// ----------------------------------------------------------------------------
// lvps_queue
// short fifo of classified items between front and back
// ----------------------------------------------------------------------------
module lvps_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  lvps_pkg::q_entry_type wr_entry,
   input  logic                  pop,
   output lvps_pkg::q_entry_type rd_entry,
   output logic                  full,
   output logic                  not_empty
);
   import lvps_pkg::*;

   q_entry_type        slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff;
   logic [Q_PTR_W-1:0] wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff;
   logic [Q_PTR_W-1:0] rd_ptr_in;
   logic [Q_CNT_W-1:0] count_ff;
   logic [Q_CNT_W-1:0] count_in;

   function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
      return (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + Q_PTR_W'(1);
   endfunction

   assign full      = count_ff == Q_CNT_W'(Q_DEPTH);
   assign not_empty = count_ff != '0;
   assign rd_entry  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + Q_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/core/lvps_divider.sv -----
// ----------------------------------------------------------------------------
// lvps_divider
// restoring divider, one quotient bit per cycle, for the tick density
// ----------------------------------------------------------------------------
module lvps_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [lvps_pkg::DVD_W-1:0]    dividend,
   input  logic [lvps_pkg::POS_W-1:0]    divisor,
   output logic [lvps_pkg::DVD_W-1:0]    quotient,
   output lvps_pkg::div_stat_type        stat
);
   import lvps_pkg::*;

   logic [DVD_W-1:0]     dvd_ff;
   logic [DVD_W-1:0]     dvd_in;
   logic [DVD_W-1:0]     quo_ff;
   logic [DVD_W-1:0]     quo_in;
   logic [POS_W-1:0]     rem_ff;
   logic [POS_W-1:0]     rem_in;
   logic [POS_W-1:0]     dsr_ff;
   logic [POS_W-1:0]     dsr_in;
   logic [DVD_CNT_W-1:0] cnt_ff;
   logic [DVD_CNT_W-1:0] cnt_in;
   logic                 busy_ff;
   logic                 busy_in;
   logic                 done_ff;
   logic                 done_in;
   logic [POS_W:0]       rem_sh;
   logic [POS_W:0]       rem_sub;
   logic                 ge;

   assign rem_sh  = {rem_ff, dvd_ff[DVD_W-1]};
   assign rem_sub = rem_sh - {1'b0, dsr_ff};
   assign ge      = rem_sh >= {1'b0, dsr_ff};

   always_comb begin
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         quo_in  = '0;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = DVD_CNT_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
         quo_in = {quo_ff[DVD_W-2:0], ge};
         rem_in = ge ? rem_sub[POS_W-1:0] : rem_sh[POS_W-1:0];
         cnt_in = cnt_ff - DVD_CNT_W'(1);
         if (cnt_ff == DVD_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// ----- rtl/core/lvps_back.sv -----
// ----------------------------------------------------------------------------
// lvps_back
// particle state memory, verlet update sequence, density and result register
// ----------------------------------------------------------------------------
`include "langevin_verlet_particle_step_top_assert.svh"

module lvps_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_valid,
   input  lvps_pkg::q_entry_type           q_rd_entry,
   output logic                            q_pop,
   input  logic [lvps_pkg::COEF_W-1:0]     damping_gamma,
   input  logic [lvps_pkg::COEF_W-1:0]     noise_scale,
   lvps_rsp_if.source                      rsp
);
   import lvps_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_HALF = 7'b0000010,
      ST_MUL  = 7'b0000100,
      ST_ACC  = 7'b0001000,
      ST_WB   = 7'b0010000,
      ST_DIV  = 7'b0100000,
      ST_DENS = 7'b1000000
   } state_type;

   state_type               state_ff;
   state_type               state_in;
   q_entry_type             item_ff;
   q_entry_type             item_in;

   pstate_type              mem_ff [MAX_PARTICLES];
   logic [MAX_PARTICLES-1:0] vld_ff;
   pstate_type              rd_ff;
   logic                    rd_vld_ff;
   logic                    rd_en;
   logic                    mem_we;
   logic [IDX_W-1:0]        mem_wa;
   pstate_type              mem_wd;

   logic signed [32:0]      half_v_ff;
   logic signed [32:0]      half_v_in;
   logic signed [POS_W-1:0] r_ff;
   logic signed [POS_W-1:0] r_in;
   logic signed [32:0]      nprod_ff;
   logic signed [32:0]      nprod_in;
   logic signed [49:0]      dprod_ff;
   logic signed [49:0]      dprod_in;
   logic signed [POS_W-1:0] a_ff;
   logic signed [POS_W-1:0] a_in;
   logic signed [POS_W-1:0] min_ff;
   logic signed [POS_W-1:0] min_in;
   logic signed [POS_W-1:0] max_ff;
   logic signed [POS_W-1:0] max_in;
   logic [DENS_W-1:0]       dens_ff;
   logic [DENS_W-1:0]       dens_in;
   logic                    zero_ff;
   logic                    zero_in;
   result_type              rsp_ff;
   result_type              rsp_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;

   logic                    out_free;
   logic signed [POS_W-1:0] cur_vel;
   logic signed [POS_W-1:0] cur_acc;
   logic signed [33:0]      pos_sum;
   logic signed [33:0]      nsum;
   logic signed [50:0]      dsum;
   logic signed [29:0]      nterm;
   logic signed [34:0]      damp;
   logic signed [33:0]      vel_sum;
   logic signed [POS_W-1:0] v_new;
   logic signed [POS_W-1:0] min_new;
   logic signed [POS_W-1:0] max_new;
   logic signed [32:0]      span;

   logic                    div_start;
   logic [DVD_W-1:0]        div_quo;
   div_stat_type            div_stat;

   lvps_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({item_ff.n, {DENS_SHIFT{1'b0}}}),
      .divisor  (span[POS_W-1:0]),
      .quotient (div_quo),
      .stat     (div_stat)
   );

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign rd_en    = q_pop && (q_rd_entry.cmd == CMD_STEP);

   // datapath terms
   always_comb begin
      cur_vel   = rd_vld_ff ? rd_ff.vel : '0;
      cur_acc   = rd_vld_ff ? rd_ff.acc : '0;
      half_v_in = 33'(cur_vel) + 33'(cur_acc >>> 1);
      pos_sum   = 34'(rd_ff.pos) + 34'(half_v_in);
      r_in      = sat32(40'(pos_sum));
      nprod_in  = 33'($signed({1'b0, noise_scale})) * 33'(item_ff.noise);
      dprod_in  = 50'($signed({1'b0, damping_gamma})) * 50'(half_v_ff);
      nsum      = 34'(nprod_ff) + 34'sd8;
      dsum      = 51'(dprod_ff) + 51'sd32768;
      nterm     = 30'(nsum >>> 4);
      damp      = 35'(dsum >>> 16);
      a_in      = sat32(40'(nterm) - 40'(damp));
      vel_sum   = 34'(half_v_ff) + 34'(a_ff >>> 1);
      v_new     = sat32(40'(vel_sum));
      min_new   = (r_ff < min_ff) ? r_ff : min_ff;
      max_new   = (r_ff > max_ff) ? r_ff : max_ff;
      span      = 33'(max_new) - 33'(min_new);
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      mem_wa       = item_ff.idx;
      mem_wd       = '{pos: r_ff, vel: v_new, acc: a_ff};
      min_in       = min_ff;
      max_in       = max_ff;
      dens_in      = dens_ff;
      zero_in      = zero_ff;
      div_start    = 1'b0;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               item_in = q_rd_entry;
               if (q_rd_entry.cmd == CMD_LOAD) begin
                  mem_we = 1'b1;
                  mem_wa = q_rd_entry.idx;
                  mem_wd = '{pos: q_rd_entry.init_pos, vel: '0, acc: '0};
                  if (q_rd_entry.end_tick) begin
                     min_in = S32_MAX;
                     max_in = S32_MIN;
                  end
               end else begin
                  state_in = ST_HALF;
               end
            end
         end
         ST_HALF: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            state_in = ST_WB;
         end
         ST_WB: begin
            if (out_free) begin
               mem_we          = 1'b1;
               rsp_valid_in    = 1'b1;
               rsp_in.kind     = KIND_POS;
               rsp_in.pidx     = PIDX_W'(item_ff.idx);
               rsp_in.position = r_ff;
               rsp_in.density  = '0;
               rsp_in.span_zero = 1'b0;
               rsp_in.last     = !item_ff.end_tick;
               if (item_ff.end_tick) begin
                  min_in = S32_MAX;
                  max_in = S32_MIN;
                  if (span[32] || span == '0) begin
                     dens_in  = '1;
                     zero_in  = 1'b1;
                     state_in = ST_DENS;
                  end else begin
                     zero_in   = 1'b0;
                     div_start = 1'b1;
                     state_in  = ST_DIV;
                  end
               end else begin
                  min_in   = min_new;
                  max_in   = max_new;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               dens_in  = (|div_quo[DVD_W-1:DENS_W]) ? '1 : div_quo[DENS_W-1:0];
               state_in = ST_DENS;
            end
         end
         ST_DENS: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_in.kind      = KIND_DENS;
               rsp_in.pidx      = PIDX_W'(item_ff.idx);
               rsp_in.position  = '0;
               rsp_in.density   = dens_ff;
               rsp_in.span_zero = zero_ff;
               rsp_in.last      = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_wa] <= mem_wd;
      end
      if (rd_en) begin
         rd_ff     <= mem_ff[q_rd_entry.idx];
         rd_vld_ff <= vld_ff[q_rd_entry.idx];
      end
   end

   // velocity and acceleration read as zero until written
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (mem_we) begin
         vld_ff[mem_wa] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      half_v_ff <= half_v_in;
      r_ff      <= r_in;
      nprod_ff  <= nprod_in;
      dprod_ff  <= dprod_in;
      a_ff      <= a_in;
      dens_ff   <= dens_in;
      zero_ff   <= zero_in;
      rsp_ff    <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         min_ff       <= S32_MAX;
         max_ff       <= S32_MIN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.result_kind    = rsp_ff.kind;
   assign rsp.particle_index = rsp_ff.pidx;
   assign rsp.position       = rsp_ff.position;
   assign rsp.density        = rsp_ff.density;
   assign rsp.span_zero      = rsp_ff.span_zero;
   assign rsp.last           = rsp_ff.last;

   `LVPS_ASSERT_SAME(a_div_running, clock, reset, state_ff == ST_DIV,
      div_stat.busy || div_stat.done, "waiting on density with divider idle")
   `LVPS_ASSERT_SAME(a_range_order, clock, reset, min_ff != S32_MAX,
      min_ff <= max_ff, "tick minimum above maximum")
   `LVPS_ASSERT_SAME(a_dens_last, clock, reset,
      rsp_valid_ff && rsp_ff.kind == KIND_DENS, rsp_ff.last,
      "density transaction not marked last")
   `LVPS_ASSERT_NEXT(a_wb_result, clock, reset, state_ff == ST_WB && out_free,
      rsp_valid_ff && rsp_ff.kind == KIND_POS, "position result not presented")

endmodule

// ----- rtl/core/langevin_verlet_particle_step_top.sv -----
// a step goes through the queue and the read, half-kick, multiply, force and
//   write-back states, the last waiting for a free result register; steps do not
//   overlap on the single-port state memory; loads go one per cycle while idle; the
//   tick density comes from the one-bit-per-cycle divider, or all ones on a zero span
// reset: synchronous, active high; all particle velocities and accelerations read
//   as zero at once (per-entry valid bits), control registers return to defaults
// ----------------------------------------------------------------------------
// langevin_verlet_particle_step_top
// damped velocity verlet stepper for a row of particles in q8.24, with tick density
// ----------------------------------------------------------------------------
module langevin_verlet_particle_step_top (
   input  logic        clock,
   input  logic        reset,
   lvps_req_if.sink    req_bus,
   lvps_rsp_if.source  rsp_bus,
   lvps_csr_if.sink    csr_bus
);
   import lvps_pkg::*;

   // configuration registers
   logic [COEF_W-1:0] gamma_ff;
   logic [COEF_W-1:0] scale_ff;
   logic [ACT_W-1:0]  active_ff;

   // front to queue
   logic              q_push;
   q_entry_type       q_wr_entry;
   logic              q_full;

   // queue to back
   logic              q_pop;
   q_entry_type       q_rd_entry;
   logic              q_not_empty;

   // register writes are always taken; an unknown index is dropped
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gamma_ff  <= GAMMA_RST;
         scale_ff  <= SCALE_RST;
         active_ff <= ACTIVE_RST;
      end else if (csr_bus.valid && csr_bus.ready) begin
         unique case (csr_bus.index)
            CSR_GAMMA:  gamma_ff  <= csr_bus.data;
            CSR_SCALE:  scale_ff  <= csr_bus.data;
            CSR_ACTIVE: active_ff <= csr_bus.data[ACT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // front: hands out the particle order and flags the last particle of a tick
   lvps_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req              (req_bus),
      .active_particles (active_ff),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_wr_entry       (q_wr_entry)
   );

   // decouples intake from the multi-cycle update
   lvps_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .wr_entry  (q_wr_entry),
      .pop       (q_pop),
      .rd_entry  (q_rd_entry),
      .full      (q_full),
      .not_empty (q_not_empty)
   );

   // back: state memory, verlet update, min/max tracking and density
   lvps_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_not_empty),
      .q_rd_entry    (q_rd_entry),
      .q_pop         (q_pop),
      .damping_gamma (gamma_ff),
      .noise_scale   (scale_ff),
      .rsp           (rsp_bus)
   );

endmodule

// ----- tb/langevin_verlet_particle_step_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// langevin_verlet_particle_step_top_test
// self-checking bench for the damped verlet particle stepper: a queue-fed
// driver and a clocked monitor check every position and tick density
// against an in-bench integrator, over several register settings and paces
// ----------------------------------------------------------------------------
module langevin_verlet_particle_step_top_test;
   import lvps_pkg::*;

   localparam int RESET_CYCLES  = 7;
   localparam int SETTLE_CYCLES = 64;     // step latency plus the density divider
   localparam int STALL_LIMIT   = 2000;   // cycles with no transaction at all
   localparam int PHASE_ITEMS   = 52;
   localparam int PHASE_COUNT   = 14;
   localparam int STEP_PCT      = 85;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;   // not decoded by the block

   typedef struct {
      cmd_type                   cmd;
      logic signed [NOISE_W-1:0] noise;
      logic signed [POS_W-1:0]   init_pos;
   } particle_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lvps_req_if req_bus ();
   lvps_rsp_if rsp_bus ();
   lvps_csr_if csr_bus ();

   langevin_verlet_particle_step_top DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #1 clock = ~clock;

   // items waiting for the driver and positions/densities waiting for the monitor
   particle_item_type stim_items [$];
   result_type        awaited_results [$];
   particle_item_type next_item;
   bit                req_busy = 1'b0;

   // pace of both sides, in percent of cycles
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;

   // integrator state, mirrors the block
   logic signed [POS_W-1:0] pos_mem [MAX_PARTICLES];
   logic signed [POS_W-1:0] vel_mem [MAX_PARTICLES];
   logic signed [POS_W-1:0] acc_mem [MAX_PARTICLES];
   logic [IDX_W-1:0]        next_idx = '0;
   logic signed [POS_W-1:0] tick_min = S32_MAX;
   logic signed [POS_W-1:0] tick_max = S32_MIN;
   logic [COEF_W-1:0]       cfg_gamma  = GAMMA_RST;
   logic [COEF_W-1:0]       cfg_scale  = SCALE_RST;
   logic [ACT_W-1:0]        cfg_active = ACTIVE_RST;

   // stimulus-side view of the particle order, so no unloaded particle gets stepped
   int unsigned gen_next = 0;
   bit          gen_loaded [MAX_PARTICLES];

   int unsigned phase_active [PHASE_COUNT];

   int unsigned fail_count  = 0;
   int unsigned quiet_cycles = 0;
   int unsigned n_loads = 0, n_steps = 0, n_positions = 0, n_densities = 0;
   int unsigned n_zero_span = 0, n_writes = 0;

   // particle count as the block uses it: 0 acts as 1, above the maximum clamps
   function automatic int unsigned eff_count(input logic [ACT_W-1:0] act);
      int unsigned n;
      n = act;
      if (n < 1) n = 1;
      if (n > MAX_PARTICLES) n = MAX_PARTICLES;
      return n;
   endfunction

   function automatic logic signed [POS_W-1:0] clamp_q824(input longint x);
      if (x > 64'sh7FFF_FFFF) return S32_MAX;
      if (x < -64'sh8000_0000) return S32_MIN;
      return x[POS_W-1:0];
   endfunction

   // one accepted transaction: update the particle and queue what it should give
   task automatic integrate_particle(input cmd_type c,
                                     input logic signed [NOISE_W-1:0] ns,
                                     input logic signed [POS_W-1:0] p);
      int unsigned n;
      int unsigned idx;
      bit          end_tick;
      longint      sample, gamma_l, scale_l, half_v, nterm, damp, span, quot;
      logic signed [POS_W-1:0] r, a, v;
      result_type  res;
      n        = eff_count(cfg_active);
      idx      = next_idx;
      end_tick = (idx >= n - 1);
      if (c == CMD_LOAD) begin
         pos_mem[idx] = p;
         vel_mem[idx] = '0;
         acc_mem[idx] = '0;
         n_loads++;
      end else begin
         sample  = ns;
         gamma_l = cfg_gamma;
         scale_l = cfg_scale;
         // half kick, drift, then the damped noisy force and the second half kick
         half_v = longint'(vel_mem[idx]) + (longint'(acc_mem[idx]) >>> 1);
         r      = clamp_q824(longint'(pos_mem[idx]) + half_v);
         nterm  = (scale_l * sample + 64'sd8) >>> 4;
         damp   = (gamma_l * half_v + 64'sd32768) >>> 16;
         a      = clamp_q824(nterm - damp);
         v      = clamp_q824(half_v + (longint'(a) >>> 1));
         pos_mem[idx] = r;
         acc_mem[idx] = a;
         vel_mem[idx] = v;
         if (r < tick_min) tick_min = r;
         if (r > tick_max) tick_max = r;
         n_steps++;

         res.kind      = KIND_POS;
         res.pidx      = PIDX_W'(idx);
         res.position  = r;
         res.density   = '0;
         res.span_zero = 1'b0;
         res.last      = !end_tick;
         awaited_results.push_back(res);

         if (end_tick) begin
            span         = longint'(tick_max) - longint'(tick_min);
            res.kind     = KIND_DENS;
            res.position = '0;
            res.last     = 1'b1;
            if (span <= 0) begin
               res.density   = '1;
               res.span_zero = 1'b1;
               n_zero_span++;
            end else begin
               quot        = (longint'(n) <<< DENS_SHIFT) / span;
               res.density = (quot > 64'shFFFF_FFFF) ? '1 : quot[DENS_W-1:0];
            end
            awaited_results.push_back(res);
         end
      end
      if (end_tick) begin
         next_idx = '0;
         tick_min = S32_MAX;
         tick_max = S32_MIN;
      end else begin
         next_idx = IDX_W'(idx + 1);
      end
   endtask

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %h, actual %h", name, want, got);
         fail_count++;
      end
   endfunction

   task automatic check_result();
      result_type want;
      if (awaited_results.size() == 0) begin
         $error("result transaction with nothing expected: kind %0d particle %0d",
                rsp_bus.result_kind, rsp_bus.particle_index);
         fail_count++;
      end else begin
         want = awaited_results.pop_front();
         compare_field("result_kind", want.kind, rsp_bus.result_kind);
         compare_field("particle_index", want.pidx, rsp_bus.particle_index);
         compare_field("position", want.position, rsp_bus.position);
         compare_field("density", want.density, rsp_bus.density);
         compare_field("span_zero", want.span_zero, rsp_bus.span_zero);
         compare_field("last", want.last, rsp_bus.last);
         if (want.kind == KIND_DENS) n_densities++;
         else n_positions++;
      end
   endtask

   // driver: one request transaction in flight, new payload only at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_busy) begin
         if (stim_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            next_item = stim_items.pop_front();
            req_bus.valid            <= 1'b1;
            req_bus.command          <= next_item.cmd;
            req_bus.noise_sample     <= next_item.noise;
            req_bus.initial_position <= next_item.init_pos;
            req_busy = 1'b1;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // result side back-pressure
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
   end

   // monitor: predict on request handshakes, check on result handshakes, watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            integrate_particle(req_bus.command, req_bus.noise_sample,
                               req_bus.initial_position);
            req_busy = 1'b0;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            check_result();
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no transaction for %0d cycles, %0d results outstanding",
                     quiet_cycles, awaited_results.size());
            $display("[langevin_verlet_particle_step_top] ERROR");
            $finish;
         end
      end
   end

   // sender holds off until every expected result is back, then lets loads settle
   task automatic wait_drained();
      while (stim_items.size() != 0 || req_busy || awaited_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      do @(posedge clock); while (!(csr_bus.valid && csr_bus.ready));
      case (idx)
         CSR_GAMMA:  cfg_gamma  = data;
         CSR_SCALE:  cfg_scale  = data;
         CSR_ACTIVE: cfg_active = data[ACT_W-1:0];
         default: ;
      endcase
      n_writes++;
   endtask

   task automatic configure(input logic [COEF_W-1:0] gamma, input logic [COEF_W-1:0] scale,
                            input logic [CSR_DATA_W-1:0] active);
      wait_drained();
      write_reg(CSR_GAMMA, gamma);
      write_reg(CSR_SCALE, scale);
      write_reg(CSR_ACTIVE, active);
      @(negedge clock) csr_bus.valid <= 1'b0;
   endtask

   task automatic set_pace(input int unsigned mode);
      case (mode % 4)
         0:       begin send_idle_pct = 0;  stall_pct = 0;  end
         1:       begin send_idle_pct = 65; stall_pct = 0;  end
         2:       begin send_idle_pct = 0;  stall_pct = 65; end
         default: begin send_idle_pct = 24; stall_pct = 24; end
      endcase
   endtask

   // follows the particle order; a step on a never-loaded particle becomes a load
   task automatic queue_item(input cmd_type c, input logic signed [NOISE_W-1:0] ns,
                             input logic signed [POS_W-1:0] p);
      particle_item_type item;
      int unsigned       n;
      n = eff_count(cfg_active);
      item.cmd = c;
      if (c == CMD_STEP && !gen_loaded[gen_next]) item.cmd = CMD_LOAD;
      item.noise    = ns;
      item.init_pos = p;
      if (item.cmd == CMD_LOAD) gen_loaded[gen_next] = 1'b1;
      gen_next = (gen_next >= n - 1) ? 0 : gen_next + 1;
      stim_items.push_back(item);
   endtask

   function automatic logic signed [NOISE_W-1:0] rand_noise();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 55) return NOISE_W'($urandom_range(8192) - 4096);   // within +-1.0
      if (sel < 85) return NOISE_W'($urandom);
      if (sel < 90) return 16'sh7FFF;
      if (sel < 95) return 16'sh8000;
      return '0;
   endfunction

   function automatic logic signed [POS_W-1:0] rand_position();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 50) return POS_W'($urandom_range(32'h0800_0000) - 32'h0400_0000);
      if (sel < 80) return POS_W'($urandom);
      if (sel < 87) return S32_MAX;
      if (sel < 94) return S32_MIN;
      return 32'sh0100_0000;   // shared value, lets spans collapse
   endfunction

   function automatic logic [COEF_W-1:0] pick_coef();
      case ($urandom_range(3))
         0:       return '0;
         1:       return '1;
         default: return COEF_W'($urandom);
      endcase
   endfunction

   task automatic queue_random_item();
      cmd_type c;
      c = ($urandom_range(99) < STEP_PCT) ? CMD_STEP : CMD_LOAD;
      queue_item(c, rand_noise(), rand_position());
   endtask

   initial begin
      req_bus.valid            = 1'b0;
      req_bus.command          = CMD_LOAD;
      req_bus.noise_sample     = '0;
      req_bus.initial_position = '0;
      rsp_bus.ready            = 1'b0;
      csr_bus.valid            = 1'b0;
      csr_bus.index            = '0;
      csr_bus.data             = '0;
      for (int i = 0; i < MAX_PARTICLES; i++) begin
         pos_mem[i]    = '0;
         vel_mem[i]    = '0;
         acc_mem[i]    = '0;
         gen_loaded[i] = 1'b0;
      end
      phase_active = '{25, 4, 1, 32, 3, 63, 8, 2, 0, 40, 5, 7, 16, 6};

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // lone particle at full gain and noise scale: a zero count acts as one,
      // every step closes its own tick on a zero span, positions pinned at the rails
      set_pace(0);
      configure(16'hFFFF, 16'hFFFF, 16'd0);
      write_reg(CSR_SPARE, CSR_DATA_W'($urandom));   // unknown index, must be ignored
      @(negedge clock) csr_bus.valid <= 1'b0;
      queue_item(CMD_LOAD, '0, S32_MAX);
      queue_item(CMD_STEP, 16'sh7FFF, '0);
      queue_item(CMD_STEP, 16'sh8000, '0);
      queue_item(CMD_LOAD, '0, S32_MIN);
      queue_item(CMD_STEP, 16'sh8000, '0);
      queue_item(CMD_STEP, 16'sh7FFF, '0);

      // two particles, no damping: a load on the last one ends the tick quietly,
      // then a span of 2.0 and a span of zero from equal positions
      configure(16'd0, SCALE_RST, 16'd2);
      queue_item(CMD_LOAD, '0, 32'sh0100_0000);
      queue_item(CMD_LOAD, '0, 32'shFF00_0000);
      queue_item(CMD_STEP, '0, '0);
      queue_item(CMD_STEP, '0, '0);
      queue_item(CMD_LOAD, '0, 32'sh0000_1234);
      queue_item(CMD_LOAD, '0, 32'sh0000_1234);
      queue_item(CMD_STEP, '0, '0);
      queue_item(CMD_STEP, '0, '0);

      // count drops below the next particle mid tick: that particle closes the tick
      configure(GAMMA_RST, SCALE_RST, 16'd6);
      repeat (6) queue_item(CMD_LOAD, rand_noise(), rand_position());
      repeat (4) queue_item(CMD_STEP, rand_noise(), '0);
      configure(GAMMA_RST, SCALE_RST, 16'd3);
      queue_item(CMD_STEP, rand_noise(), '0);

      // random phases: mostly full ticks of steps, reloads mixed in, paces rotated
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         if (ph == 0) begin
            configure(GAMMA_RST, SCALE_RST, CSR_DATA_W'(ACTIVE_RST));
         end else begin
            configure(pick_coef(), pick_coef(),
                      {10'($urandom), 6'(phase_active[ph])});
         end
         set_pace(ph);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            // in every third phase, pause mid phase until all results are back
            if (ph % 3 == 1 && k == PHASE_ITEMS / 2) wait_drained();
            queue_random_item();
         end
      end

      wait_drained();
      $display("covered %0d loads and %0d steps; checked %0d positions, %0d densities",
               n_loads, n_steps, n_positions, n_densities);
      $display("%0d densities on a collapsed span, %0d register writes, %0d failures",
               n_zero_span, n_writes, fail_count);
      if (fail_count == 0 && awaited_results.size() == 0) begin
         $display("[langevin_verlet_particle_step_top] OK");
      end else begin
         $display("[langevin_verlet_particle_step_top] ERROR");
      end
      $finish;
   end

endmodule
